@@ src/fp32_matrix_vector_multiply_assert.svh @@
// Assertion macros for the single-precision matrix-vector multiply.
// Used by the port-level checker; depends on signals named clk and rst_n.
`ifndef FP32_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define FP32_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmv port assertion failed");

// Next-cycle implication, disabled during reset.
`define FMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmv port assertion failed");

`endif

@@ src/fmv_pkg.sv @@
// Shared constants, types and helper functions of the matrix-vector multiply.
// No dependencies; used by every module of the block.
`default_nettype none

package fmv_pkg;

    localparam int MAX_DIM = 1024;
    localparam int LANES = 8;
    localparam int ADDR_W = $clog2(MAX_DIM);
    localparam int LANE_W = $clog2(LANES);
    localparam int GROUP_W = 8;
    localparam int MAX_GROUPS = MAX_DIM / LANES;
    localparam int FP_W = 32;
    localparam int SIG_W = 24;
    localparam int MANT_W = 48;
    localparam int SUM_W = 76;
    localparam int LOW_W = SUM_W - 1 - MANT_W;
    localparam int EXP_W = 11;
    localparam int LZ_W = 7;
    localparam int STEP_W = 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    localparam logic [FP_W-1:0] FP_ONE = 32'h3F80_0000;
    localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

    localparam logic signed [EXP_W-1:0] ADDEND_BIAS = 11'sd126;
    localparam logic signed [EXP_W-1:0] DENORM_LIMIT = 11'sd126;
    localparam logic signed [EXP_W-1:0] PACK_BIAS = 11'sd125;
    localparam logic signed [EXP_W-1:0] SUM_W_E = 11'sd76;
    localparam logic signed [EXP_W-1:0] EXP_MAX = 11'sd255;

    localparam logic [STEP_W-1:0] RED_LAST = 3'd6;

    typedef struct packed {
        logic start;
        logic no_addend;
    } fmv_req_t;

    typedef struct packed {
        logic            done;
        logic [FP_W-1:0] result;
    } fmv_rsp_t;

    function automatic logic [LZ_W-1:0] lzc48(input logic [MANT_W-1:0] x);
        logic [LZ_W-1:0] n;
        n = LZ_W'(MANT_W);
        for (int i = 0; i < MANT_W; i++) begin
            if (x[i]) n = LZ_W'(MANT_W - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [LZ_W-1:0] lzc76(input logic [SUM_W-1:0] x);
        logic [LZ_W-1:0] n;
        n = LZ_W'(SUM_W);
        for (int i = 0; i < SUM_W; i++) begin
            if (x[i]) n = LZ_W'(SUM_W - 1 - i);
        end
        return n;
    endfunction

    // Pairwise reduction ((x0+x4)+(x2+x6))+((x1+x5)+(x3+x7)) done in place.
    function automatic logic [LANE_W-1:0] red_src_a(input logic [STEP_W-1:0] s);
        logic [LANE_W-1:0] r;
        case (s)
            3'd0: r = 3'd0;
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd3: r = 3'd3;
            3'd4: r = 3'd0;
            3'd5: r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [LANE_W-1:0] red_src_b(input logic [STEP_W-1:0] s);
        logic [LANE_W-1:0] r;
        case (s)
            3'd0: r = 3'd4;
            3'd1: r = 3'd6;
            3'd2: r = 3'd5;
            3'd3: r = 3'd7;
            3'd4: r = 3'd2;
            3'd5: r = 3'd3;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [LANE_W-1:0] red_dst(input logic [STEP_W-1:0] s);
        logic [LANE_W-1:0] r;
        case (s)
            3'd0: r = 3'd0;
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd3: r = 3'd3;
            3'd4: r = 3'd0;
            3'd5: r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/fmv_fma.sv @@
// Five-stage single-precision fused multiply-add, one rounding, subnormals kept.
// Depends on fmv_pkg; computes a*b+c, or a*b alone when no_addend is set.
`default_nettype none

module fmv_fma (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fmv_pkg::fmv_req_t         req,
    input  logic [fmv_pkg::FP_W-1:0]  a,
    input  logic [fmv_pkg::FP_W-1:0]  b,
    input  logic [fmv_pkg::FP_W-1:0]  c,
    output fmv_pkg::fmv_rsp_t         rsp
);
    import fmv_pkg::*;

    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
    logic        sp, sc, prod_inf, is_nan;
    logic [SIG_W-1:0] sig_a, sig_b, sig_c;
    logic [FP_W-1:0]  spec_val;
    logic             spec;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    s1_sp_reg, s1_sc_reg, s1_pz_reg, s1_cz_reg;
    logic                    s1_zsign_reg, s1_spec_reg;
    logic [FP_W-1:0]         s1_spec_val_reg;
    logic [MANT_W-1:0]       s1_prod_reg;
    logic signed [EXP_W-1:0] s1_ep_reg, s1_ec_reg;
    logic [SIG_W-1:0]        s1_sigc_reg;

    logic [LZ_W-1:0]         lzp, lzcc;
    logic [MANT_W-1:0]       mc_raw;
    logic                    s2_sp_reg, s2_sc_reg, s2_pz_reg, s2_cz_reg;
    logic                    s2_zsign_reg, s2_spec_reg;
    logic [FP_W-1:0]         s2_spec_val_reg;
    logic [MANT_W-1:0]       s2_mp_reg, s2_mc_reg;
    logic signed [EXP_W-1:0] s2_ep_reg, s2_ec_reg;

    logic                    p_big, small_zero, sub, sticky;
    logic [MANT_W-1:0]       m_big, m_small;
    logic signed [EXP_W-1:0] e_big, e_small, dd;
    logic [SUM_W-1:0]        big_w, small_w, shifted, sum;
    logic                    s3_sign_reg, s3_both_zero_reg, s3_zsign_reg, s3_spec_reg;
    logic [FP_W-1:0]         s3_spec_val_reg;
    logic [SUM_W-1:0]        s3_sum_reg;
    logic signed [EXP_W-1:0] s3_ebig_reg;

    logic                    s4_sign_reg, s4_zero_reg, s4_zsign_reg, s4_spec_reg;
    logic [FP_W-1:0]         s4_spec_val_reg;
    logic [SUM_W-1:0]        s4_sum_reg;
    logic signed [EXP_W-1:0] s4_ebig_reg;
    logic [LZ_W-1:0]         s4_lz_reg;

    logic signed [EXP_W-1:0] t_lim, l_s, amt, rs, fexp;
    logic [SUM_W-1:0]        xs;
    logic                    rsticky, guard, rst_all, rnd;
    logic [FP_W-2:0]         packed_mag;
    logic [FP_W-1:0]         result;
    logic                    done_reg;
    logic [FP_W-1:0]         result_reg;

    always_comb
    begin
        ea = a[30:23]; fa = a[22:0];
        eb = b[30:23]; fb = b[22:0];
        ec = c[30:23]; fc = c[22:0];
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        c_zero = (ec == 8'd0) && (fc == 23'd0);
        a_inf = (ea == 8'hFF) && (fa == 23'd0);
        b_inf = (eb == 8'hFF) && (fb == 23'd0);
        c_inf = (ec == 8'hFF) && (fc == 23'd0);
        a_nan = (ea == 8'hFF) && (fa != 23'd0);
        b_nan = (eb == 8'hFF) && (fb != 23'd0);
        c_nan = (ec == 8'hFF) && (fc != 23'd0);
        sig_a = {|ea, fa};
        sig_b = {|eb, fb};
        sig_c = {|ec, fc};
        sp = a[31] ^ b[31];
        sc = c[31];
        prod_inf = a_inf || b_inf;
        is_nan = a_nan || b_nan || (!req.no_addend && c_nan)
              || (a_inf && b_zero) || (b_inf && a_zero)
              || (prod_inf && !req.no_addend && c_inf && (sp != sc));
        spec = is_nan || prod_inf || (!req.no_addend && c_inf);
        if (is_nan) spec_val = FP_QNAN;
        else if (prod_inf) spec_val = {sp, 8'hFF, 23'd0};
        else spec_val = {sc, 8'hFF, 23'd0};
    end

    always_comb
    begin
        lzp = lzc48(s1_prod_reg);
        mc_raw = {s1_sigc_reg, {(MANT_W - SIG_W){1'b0}}};
        lzcc = lzc48(mc_raw);
    end

    always_comb
    begin
        if (s2_cz_reg) p_big = 1'b1;
        else if (s2_pz_reg) p_big = 1'b0;
        else p_big = (s2_ep_reg > s2_ec_reg)
                  || ((s2_ep_reg == s2_ec_reg) && (s2_mp_reg >= s2_mc_reg));
        small_zero = s2_pz_reg || s2_cz_reg;
        m_big = p_big ? s2_mp_reg : s2_mc_reg;
        m_small = p_big ? s2_mc_reg : s2_mp_reg;
        e_big = p_big ? s2_ep_reg : s2_ec_reg;
        e_small = p_big ? s2_ec_reg : s2_ep_reg;
        sub = s2_sp_reg ^ s2_sc_reg;
        dd = e_big - e_small;
        big_w = {1'b0, m_big, {LOW_W{1'b0}}};
        small_w = {1'b0, m_small, {LOW_W{1'b0}}};
        if (small_zero) begin
            shifted = '0;
            sticky = 1'b0;
        end else if (dd >= SUM_W_E) begin
            shifted = '0;
            sticky = |m_small;
        end else begin
            shifted = small_w >> dd[LZ_W-1:0];
            sticky = |(small_w & ~({SUM_W{1'b1}} << dd[LZ_W-1:0]));
        end
        shifted[0] = shifted[0] | sticky;
        sum = sub ? (big_w - shifted) : (big_w + shifted);
    end

    always_comb
    begin
        t_lim = s4_ebig_reg - DENORM_LIMIT;
        l_s = $signed({{(EXP_W - LZ_W){1'b0}}, s4_lz_reg});
        amt = (t_lim < l_s) ? t_lim : l_s;
        rs = -amt;
        rst_all = 1'b0;
        if (!amt[EXP_W-1]) begin
            xs = s4_sum_reg << amt[LZ_W-1:0];
            rsticky = 1'b0;
        end else if (rs >= SUM_W_E) begin
            xs = '0;
            rsticky = |s4_sum_reg;
            rst_all = 1'b1;
        end else begin
            xs = s4_sum_reg >> rs[LZ_W-1:0];
            rsticky = |(s4_sum_reg & ~({SUM_W{1'b1}} << rs[LZ_W-1:0]));
        end
        fexp = xs[SUM_W-1] ? (s4_ebig_reg - PACK_BIAS - amt) : '0;
        guard = xs[SUM_W-1-SIG_W];
        rnd = guard && (rsticky || rst_all || (|xs[SUM_W-2-SIG_W:0]) || xs[SUM_W-SIG_W]);
        packed_mag = {fexp[7:0], xs[SUM_W-2:SUM_W-SIG_W]} + {30'd0, rnd};
        if (s4_spec_reg) result = s4_spec_val_reg;
        else if (s4_zero_reg) result = {s4_zsign_reg, 31'd0};
        else if (fexp >= EXP_MAX) result = {s4_sign_reg, 8'hFF, 23'd0};
        else result = {s4_sign_reg, packed_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sp_reg <= sp;
        s1_sc_reg <= sc;
        s1_pz_reg <= a_zero || b_zero;
        s1_cz_reg <= req.no_addend || c_zero;
        s1_zsign_reg <= req.no_addend ? sp : (sp & sc);
        s1_spec_reg <= spec;
        s1_spec_val_reg <= spec_val;
        s1_prod_reg <= sig_a * sig_b;
        s1_ep_reg <= $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                   + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb});
        s1_ec_reg <= $signed({3'd0, (ec == 8'd0) ? 8'd1 : ec}) + ADDEND_BIAS;
        s1_sigc_reg <= sig_c;

        s2_sp_reg <= s1_sp_reg;
        s2_sc_reg <= s1_sc_reg;
        s2_pz_reg <= s1_pz_reg;
        s2_cz_reg <= s1_cz_reg;
        s2_zsign_reg <= s1_zsign_reg;
        s2_spec_reg <= s1_spec_reg;
        s2_spec_val_reg <= s1_spec_val_reg;
        s2_mp_reg <= s1_prod_reg << lzp;
        s2_ep_reg <= s1_ep_reg - $signed({{(EXP_W - LZ_W){1'b0}}, lzp});
        s2_mc_reg <= mc_raw << lzcc;
        s2_ec_reg <= s1_ec_reg - $signed({{(EXP_W - LZ_W){1'b0}}, lzcc});

        s3_sign_reg <= p_big ? s2_sp_reg : s2_sc_reg;
        s3_both_zero_reg <= s2_pz_reg && s2_cz_reg;
        s3_zsign_reg <= s2_zsign_reg;
        s3_spec_reg <= s2_spec_reg;
        s3_spec_val_reg <= s2_spec_val_reg;
        s3_sum_reg <= sum;
        s3_ebig_reg <= e_big;

        s4_sign_reg <= s3_sign_reg;
        s4_zero_reg <= s3_both_zero_reg || (s3_sum_reg == '0);
        s4_zsign_reg <= s3_both_zero_reg ? s3_zsign_reg : 1'b0;
        s4_spec_reg <= s3_spec_reg;
        s4_spec_val_reg <= s3_spec_val_reg;
        s4_sum_reg <= s3_sum_reg;
        s4_ebig_reg <= s3_ebig_reg;
        s4_lz_reg <= lzc76(s3_sum_reg);

        result_reg <= result;
    end

    assign rsp = {done_reg, result_reg};

endmodule

`default_nettype wire

@@ src/fp32_matrix_vector_multiply.sv @@
// Matrix-vector multiply: vector store, lane-sum store, sequencer and reduction.
// Depends on fmv_pkg and fmv_fma.
// A vector element is stored while the block stays idle; a matrix element keeps it busy
// until the five-stage multiply-add unit, which runs one operation at a time, answers.
// The last element of a row then reduces the eight lane sums in seven additions.
// Reset is asynchronous; the stores need no clearing pass and the block is ready at once.
`default_nettype none

module fp32_matrix_vector_multiply (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [fmv_pkg::FP_W-1:0]      value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fmv_pkg::GROUP_W-1:0]   cfg_data,
    output logic                          done,
    output logic [fmv_pkg::FP_W-1:0]      row_result,
    output logic [fmv_pkg::ADDR_W-1:0]    row_index,
    output logic                          last_row
);
    import fmv_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MAC_EXEC = 7'b0000010,
        ST_MAC_WAIT = 7'b0000100,
        ST_RED_A    = 7'b0001000,
        ST_RED_B    = 7'b0010000,
        ST_RED_EXEC = 7'b0100000,
        ST_RED_WAIT = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [FP_W-1:0]     value_reg, value_next;
    logic [ADDR_W-1:0]   load_ptr_reg, load_ptr_next;
    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]   row_reg, row_next;
    logic [ADDR_W-1:0]   dim_last_reg, dim_last_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [FP_W-1:0]     opa_reg, opa_next;
    logic                done_reg, done_next;
    logic [FP_W-1:0]     row_result_reg, row_result_next;
    logic [ADDR_W-1:0]   row_index_reg, row_index_next;
    logic                last_row_reg, last_row_next;

    logic [FP_W-1:0]     vec_mem [MAX_DIM];
    logic [FP_W-1:0]     vec_rdata_reg;
    logic [FP_W-1:0]     lane_mem [LANES];
    logic [FP_W-1:0]     lane_rdata_reg;
    logic                vec_we, lane_we;
    logic [LANE_W-1:0]   lane_raddr, lane_waddr;

    logic [ADDR_W:0]     groups, dim;
    logic                accept;
    fmv_req_t            req;
    fmv_rsp_t            rsp;
    logic [FP_W-1:0]     op_a, op_b;
    logic                res_nan;

    fmv_fma u_fma (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .a     (op_a),
        .b     (op_b),
        .c     (lane_rdata_reg),
        .rsp   (rsp)
    );

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign done = done_reg;
    assign row_result = row_result_reg;
    assign row_index = row_index_reg;
    assign last_row = last_row_reg;

    always_comb
    begin
        groups = {{(ADDR_W + 1 - GROUP_W){1'b0}}, cfg_data};
        if (groups == '0) groups = (ADDR_W + 1)'(1);
        else if (groups > (ADDR_W + 1)'(MAX_GROUPS)) groups = (ADDR_W + 1)'(MAX_GROUPS);
        dim = (groups << LANE_W) - (ADDR_W + 1)'(1);
        res_nan = (rsp.result[30:23] == 8'hFF) && (rsp.result[22:0] != 23'd0);
        op_a = (state_reg == ST_RED_EXEC) ? opa_reg : value_reg;
        op_b = (state_reg == ST_RED_EXEC) ? FP_ONE : vec_rdata_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        load_ptr_next = load_ptr_reg;
        col_next = col_reg;
        row_next = row_reg;
        dim_last_next = dim_last_reg;
        step_next = step_reg;
        opa_next = opa_reg;
        done_next = 1'b0;
        row_result_next = row_result_reg;
        row_index_next = row_index_reg;
        last_row_next = last_row_reg;
        vec_we = 1'b0;
        lane_we = 1'b0;
        lane_raddr = col_reg[LANE_W-1:0];
        lane_waddr = col_reg[LANE_W-1:0];
        req.start = 1'b0;
        req.no_addend = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid) begin
                    dim_last_next = dim[ADDR_W-1:0];
                    load_ptr_next = '0;
                    col_next = '0;
                    row_next = '0;
                end
                if (accept && (cmd == CMD_LOAD)) begin
                    vec_we = 1'b1;
                    load_ptr_next = (load_ptr_reg == dim_last_reg) ? '0
                                  : load_ptr_reg + ADDR_W'(1);
                end
                if (accept && (cmd == CMD_MATRIX)) begin
                    value_next = value;
                    state_next = ST_MAC_EXEC;
                end
            end
            ST_MAC_EXEC:
            begin
                req.start = 1'b1;
                req.no_addend = (col_reg[ADDR_W-1:LANE_W] == '0);
                state_next = ST_MAC_WAIT;
            end
            ST_MAC_WAIT:
            begin
                if (rsp.done) begin
                    lane_we = 1'b1;
                    if (col_reg == dim_last_reg) begin
                        col_next = '0;
                        step_next = '0;
                        state_next = ST_RED_A;
                    end else begin
                        col_next = col_reg + ADDR_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RED_A:
            begin
                lane_raddr = red_src_a(step_reg);
                state_next = ST_RED_B;
            end
            ST_RED_B:
            begin
                lane_raddr = red_src_b(step_reg);
                opa_next = lane_rdata_reg;
                state_next = ST_RED_EXEC;
            end
            ST_RED_EXEC:
            begin
                req.start = 1'b1;
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                lane_waddr = red_dst(step_reg);
                if (rsp.done) begin
                    if (step_reg == RED_LAST) begin
                        done_next = 1'b1;
                        row_result_next = res_nan ? FP_QNAN : rsp.result;
                        row_index_next = row_reg;
                        last_row_next = (row_reg == dim_last_reg);
                        row_next = (row_reg == dim_last_reg) ? '0 : row_reg + ADDR_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        lane_we = 1'b1;
                        step_next = step_reg + STEP_W'(1);
                        state_next = ST_RED_A;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            load_ptr_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            dim_last_reg <= ADDR_W'(LANES - 1);
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            load_ptr_reg <= load_ptr_next;
            col_reg <= col_next;
            row_reg <= row_next;
            dim_last_reg <= dim_last_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        opa_reg <= opa_next;
        row_result_reg <= row_result_next;
        row_index_reg <= row_index_next;
        last_row_reg <= last_row_next;
    end

    always_ff @(posedge clk)
    begin
        if (vec_we) vec_mem[load_ptr_reg] <= value;
        vec_rdata_reg <= vec_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lane_we) lane_mem[lane_waddr] <= rsp.result;
        lane_rdata_reg <= lane_mem[lane_raddr];
    end

endmodule

`default_nettype wire

@@ src/fmv_checker.sv @@
// Port-level checker for the matrix-vector multiply, bound to the top level.
// Depends on fmv_pkg and fp32_matrix_vector_multiply_assert.svh.
`default_nettype none

`include "fp32_matrix_vector_multiply_assert.svh"

module fmv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          cmd,
    input logic                          cfg_ready,
    input logic                          done
);
    import fmv_pkg::*;

    // A result beat only closes a busy period.
    `FMV_ASSERT_NOW(a_done_after_busy, done, $past(busy))
    // Result beats are isolated single-cycle strobes.
    `FMV_ASSERT_NEXT(a_done_single, done, !done)
    // Storing a vector element leaves the block idle.
    `FMV_ASSERT_NEXT(a_load_no_busy, start && !busy && (cmd == CMD_LOAD), !busy)
    // A matrix element always occupies the block.
    `FMV_ASSERT_NEXT(a_mac_busy, start && !busy && (cmd == CMD_MATRIX), busy)
    // Configuration is refused while an element is in progress.
    `FMV_ASSERT_NOW(a_cfg_idle, busy, !cfg_ready)

endmodule

bind fp32_matrix_vector_multiply fmv_checker u_fmv_checker (.*);

`default_nettype wire
